@@ hw/rtl/lss_pkg.sv @@
`timescale 1ns / 1ps
package lss_pkg;

	// stack geometry
	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = 5;
	localparam int WORD_W = 32;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// stream widths
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 3;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;
	localparam int M_TUSER_W = STATUS_W;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] RS_PUSHED = 3'd0;
	localparam logic [STATUS_W-1:0] RS_FULL   = 3'd1;
	localparam logic [STATUS_W-1:0] RS_POPPED = 3'd2;
	localparam logic [STATUS_W-1:0] RS_EMPTY  = 3'd3;
	localparam logic [STATUS_W-1:0] RS_MATCH  = 3'd4;
	localparam logic [STATUS_W-1:0] RS_DONE   = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0]  op;
		logic [WORD_W-1:0] value;
	} cmd_item_t;

endpackage

@@ hw/rtl/lss_front.sv @@
`timescale 1ns / 1ps
module lss_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lss_pkg::S_TDATA_W-1:0] s_tdata,   // cmd[1:0], data_value[33:2], zero pad
	output logic                          q_wr_valid,
	input  logic                          q_wr_ready,
	output lss_pkg::cmd_item_t            q_wr_item
);

	logic                      valid_s1;
	lss_pkg::cmd_item_t        item_s1;
	logic [lss_pkg::CMD_W-1:0] cmd;

	assign cmd        = s_tdata[lss_pkg::CMD_W-1:0];
	assign s_tready   = !valid_s1 || q_wr_ready;
	assign q_wr_valid = valid_s1;
	assign q_wr_item  = item_s1;

	// unused command code is dropped here and never reaches the back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= (cmd != lss_pkg::CMD_NOP);
		end else if (q_wr_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op    <= cmd;
			item_s1.value <= s_tdata[lss_pkg::CMD_W +: lss_pkg::WORD_W];
		end
	end

endmodule

@@ hw/rtl/lss_queue.sv @@
`timescale 1ns / 1ps
module lss_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               wr_ready,
	input  lss_pkg::cmd_item_t wr_item,
	output logic               rd_valid,
	input  logic               rd_ready,
	output lss_pkg::cmd_item_t rd_item
);

	lss_pkg::cmd_item_t          slot_q [lss_pkg::QUEUE_DEPTH];
	logic [lss_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [lss_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [lss_pkg::QCNT_W-1:0]  count_q;
	logic                        do_wr;
	logic                        do_rd;

	assign wr_ready = (count_q != lss_pkg::QCNT_W'(lss_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	function automatic logic [lss_pkg::QPTR_W-1:0] next_ptr(input logic [lss_pkg::QPTR_W-1:0] p);
		if (p == lss_pkg::QPTR_W'(lss_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end else begin
			return p + 1'b1;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lss_pkg::QCNT_W'(lss_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

@@ hw/rtl/lss_back.sv @@
`timescale 1ns / 1ps
module lss_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_rd_valid,
	output logic                          q_rd_ready,
	input  lss_pkg::cmd_item_t            q_rd_item,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lss_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [lss_pkg::M_TUSER_W-1:0] m_tuser,
	output logic                          m_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [lss_pkg::FILL_W-1:0] FULL_FILL = lss_pkg::FILL_W'(lss_pkg::DEPTH);

	logic [lss_pkg::WORD_W-1:0]   mem_q [lss_pkg::DEPTH];
	logic [1:0]                   state_q, state_d;
	logic [lss_pkg::FILL_W-1:0]   fill_q, fill_d;
	logic [lss_pkg::IDX_W-1:0]    idx_q, idx_d;
	logic [lss_pkg::WORD_W-1:0]   key_q;
	logic [lss_pkg::IDX_W-1:0]    rd_addr;
	logic [lss_pkg::WORD_W-1:0]   rd_word;
	logic                         can_emit;
	logic                         take;
	logic                         wr_en;
	logic                         emit;
	logic [lss_pkg::STATUS_W-1:0] e_status;
	logic [lss_pkg::WORD_W-1:0]   e_word;
	logic [lss_pkg::FILL_W-1:0]   e_pos;
	logic [lss_pkg::FILL_W-1:0]   e_fill;
	logic                         e_last;

	logic                         m_valid_q;
	logic [lss_pkg::STATUS_W-1:0] m_status_q;
	logic [lss_pkg::WORD_W-1:0]   m_word_q;
	logic [lss_pkg::FILL_W-1:0]   m_pos_q;
	logic [lss_pkg::FILL_W-1:0]   m_fill_q;
	logic                         m_last_q;

	assign can_emit   = !m_valid_q || m_tready;
	assign q_rd_ready = (state_q == ST_IDLE) && can_emit;
	assign take       = q_rd_ready && q_rd_valid;

	// scan walks down from the top; otherwise the top entry is read for pop
	assign rd_addr = (state_q == ST_SCAN) ? idx_q
	                                      : lss_pkg::IDX_W'(fill_q - 1'b1);
	assign rd_word = mem_q[rd_addr];

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		idx_d    = idx_q;
		wr_en    = 1'b0;
		emit     = 1'b0;
		e_status = lss_pkg::RS_DONE;
		e_word   = '0;
		e_pos    = '0;
		e_fill   = fill_q;
		e_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					unique case (q_rd_item.op)
						lss_pkg::CMD_PUSH: begin
							emit = 1'b1;
							if (fill_q == FULL_FILL) begin
								e_status = lss_pkg::RS_FULL;
							end else begin
								wr_en    = 1'b1;
								fill_d   = fill_q + 1'b1;
								e_status = lss_pkg::RS_PUSHED;
								e_fill   = fill_d;
							end
						end
						lss_pkg::CMD_POP: begin
							emit = 1'b1;
							if (fill_q == '0) begin
								e_status = lss_pkg::RS_EMPTY;
							end else begin
								fill_d   = fill_q - 1'b1;
								e_status = lss_pkg::RS_POPPED;
								e_word   = rd_word;
								e_fill   = fill_d;
							end
						end
						lss_pkg::CMD_SEARCH: begin
							if (fill_q == '0) begin
								emit = 1'b1;
							end else begin
								state_d = ST_SCAN;
								idx_d   = lss_pkg::IDX_W'(fill_q - 1'b1);
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (can_emit) begin
					if (rd_word == key_q) begin
						emit     = 1'b1;
						e_status = lss_pkg::RS_MATCH;
						e_word   = rd_word;
						e_pos    = fill_q - lss_pkg::FILL_W'(idx_q);
						e_last   = 1'b0;
					end
					if (idx_q == '0) begin
						state_d = ST_DONE;
					end else begin
						idx_d = idx_q - 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (can_emit) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			idx_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			idx_q   <= idx_d;
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[fill_q[lss_pkg::IDX_W-1:0]] <= q_rd_item.value;
		end
		if (take) begin
			key_q <= q_rd_item.value;
		end
		if (emit) begin
			m_status_q <= e_status;
			m_word_q   <= e_word;
			m_pos_q    <= e_pos;
			m_fill_q   <= e_fill;
			m_last_q   <= e_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {(lss_pkg::M_TDATA_W - lss_pkg::WORD_W - 2 * lss_pkg::FILL_W)'(0),
	                   m_fill_q, m_pos_q, m_word_q};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_FILL)
		else $error("fill count beyond depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (fill_q != '0) && (lss_pkg::FILL_W'(idx_q) < fill_q))
		else $error("scan index outside held words");

	a_match_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_status_q == lss_pkg::RS_MATCH) |-> !m_last_q)
		else $error("match beat marked last");

	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !q_rd_ready)
		else $error("queue read during search");

endmodule

@@ hw/rtl/lifo_stack_with_search_unit.sv @@
`timescale 1ns / 1ps
// a push or pop result beat passes the front register, a queue slot and the output register
// throughput: push and pop run at one beat per cycle while results are taken; a search occupies
//   the back end for its start, one step per held word through the single read port, and the done beat
// a two-entry command queue lets input keep flowing while a search drains
// reset clears fill count, queue and handshake state; stack words stay unknown
module lifo_stack_with_search_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lss_pkg::S_TDATA_W-1:0] s_tdata,   // cmd[1:0], data_value[33:2], zero pad
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lss_pkg::M_TDATA_W-1:0] m_tdata,   // word[31:0], position[36:32], fill[41:37], zero pad
	output logic [lss_pkg::M_TUSER_W-1:0] m_tuser,   // status[2:0]
	output logic                          m_tlast    // final beat of a command
);

	// front to queue
	logic               fq_valid;
	logic               fq_ready;
	lss_pkg::cmd_item_t fq_item;

	// queue to back
	logic               qb_valid;
	logic               qb_ready;
	lss_pkg::cmd_item_t qb_item;

	// front: takes beats, drops the unused command code, registers the rest
	lss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.q_wr_valid (fq_valid),
		.q_wr_ready (fq_ready),
		.q_wr_item  (fq_item)
	);

	// short command queue decoupling the two halves
	lss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_item  (fq_item),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_item  (qb_item)
	);

	// back: owns the stack store, runs push, pop and the top-down search scan,
	// and holds each result in an output register until taken
	lss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_rd_valid (qb_valid),
		.q_rd_ready (qb_ready),
		.q_rd_item  (qb_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

@@ tb/tb_lifo_stack_with_search_unit.sv @@
`timescale 1ns / 1ps
module tb_lifo_stack_with_search_unit;
	import lss_pkg::*;

	localparam int STALL_LIMIT = 2000;   // cycles with no beat on either side
	localparam int HOLD_CYCLES = 400;    // long receiver hold-off
	localparam int DRAIN_TAIL  = 20;
	localparam int PHASE_ITEMS = 44;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   word;
		logic [4:0]          position;
		logic [FILL_W-1:0]   fill;
		logic                is_last;
	} stack_beat_t;

	typedef struct packed {
		logic [CMD_W-1:0]  op;
		logic [WORD_W-1:0] value;
		logic [4:0]        reps;
		logic              typed;
		stack_beat_t       typed_beat;
	} cmd_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 m_tlast;

	// shadow stack and the beats it says must come out, oldest first
	logic [WORD_W-1:0] shadow_words [DEPTH];
	int unsigned       shadow_fill;
	stack_beat_t       pending_beats [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_request   = 0;
	int mismatch_count = 0;
	int quiet_cycles   = 0;
	logic [WORD_W-1:0] key_pool [4];

	// rows with a typed result are the obvious ones: empty, full, extremes
	cmd_row_t directed_rows [0:14] = '{
		'{CMD_POP,    32'h0,        5'd1,  1'b1, '{RS_EMPTY,  32'h0, 5'd0, 5'd0, 1'b1}},
		'{CMD_SEARCH, 32'h0,        5'd1,  1'b1, '{RS_DONE,   32'h0, 5'd0, 5'd0, 1'b1}},
		'{CMD_NOP,    32'hffffffff, 5'd1,  1'b0, '0},
		'{CMD_PUSH,   32'h80000000, 5'd1,  1'b1, '{RS_PUSHED, 32'h0, 5'd0, 5'd1, 1'b1}},
		'{CMD_PUSH,   32'h7fffffff, 5'd1,  1'b1, '{RS_PUSHED, 32'h0, 5'd0, 5'd2, 1'b1}},
		'{CMD_SEARCH, 32'h80000000, 5'd1,  1'b0, '0},
		'{CMD_POP,    32'hffffffff, 5'd1,  1'b1,
			'{RS_POPPED, 32'h7fffffff, 5'd0, 5'd1, 1'b1}},
		'{CMD_PUSH,   32'hffffffff, 5'd1,  1'b0, '0},
		'{CMD_SEARCH, 32'hffffffff, 5'd1,  1'b0, '0},
		'{CMD_POP,    32'h0,        5'd2,  1'b0, '0},
		// fill to the brim with one value so a search returns every slot
		'{CMD_PUSH,   32'h5a5aa5a5, 5'd16, 1'b0, '0},
		'{CMD_PUSH,   32'h00000001, 5'd1,  1'b1, '{RS_FULL,   32'h0, 5'd0, 5'd16, 1'b1}},
		'{CMD_SEARCH, 32'h5a5aa5a5, 5'd1,  1'b0, '0},
		'{CMD_NOP,    32'h0,        5'd1,  1'b0, '0},
		'{CMD_POP,    32'h0,        5'd1,  1'b1,
			'{RS_POPPED, 32'h5a5aa5a5, 5'd0, 5'd15, 1'b1}}
	};

	lifo_stack_with_search_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one accepted command to the shadow stack and queue its beats
	task automatic predict_stack_op(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] value);
		int n_match;
		stack_beat_t b;
		n_match = 0;
		b = '0;
		case (op)
			CMD_PUSH: begin
				b.is_last = 1'b1;
				if (shadow_fill >= DEPTH) begin
					b.status = RS_FULL;
				end else begin
					shadow_words[shadow_fill] = value;
					shadow_fill++;
					b.status = RS_PUSHED;
				end
				b.fill = FILL_W'(shadow_fill);
				pending_beats.push_back(b);
			end
			CMD_POP: begin
				b.is_last = 1'b1;
				if (shadow_fill == 0) begin
					b.status = RS_EMPTY;
				end else begin
					shadow_fill--;
					b.status = RS_POPPED;
					b.word   = shadow_words[shadow_fill];
				end
				b.fill = FILL_W'(shadow_fill);
				pending_beats.push_back(b);
			end
			CMD_SEARCH: begin
				// walk from the top down, one match beat per equal word
				for (int pos = 1; pos <= shadow_fill; pos++) begin
					if (shadow_words[shadow_fill - pos] == value && n_match < DEPTH) begin
						b = '0;
						b.status   = RS_MATCH;
						b.word     = value;
						b.position = 5'(pos);
						b.fill     = FILL_W'(shadow_fill);
						pending_beats.push_back(b);
						n_match++;
					end
				end
				b = '0;
				b.status  = RS_DONE;
				b.fill    = FILL_W'(shadow_fill);
				b.is_last = 1'b1;
				pending_beats.push_back(b);
			end
			default: ;  // unused code: nothing comes out
		endcase
	endtask

	// offer one command beat; valid stays high into the next call unless a gap is drawn
	task automatic drive_cmd(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] value,
			input logic typed, input stack_beat_t typed_beat);
		int n_before;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - WORD_W - CMD_W){1'b0}}, value, op};
		do @(posedge clk); while (!s_tready);
		n_before = pending_beats.size();
		predict_stack_op(op, value);
		if (typed) begin
			while (pending_beats.size() > n_before)
				void'(pending_beats.pop_back());
			pending_beats.push_back(typed_beat);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
	endtask

	// random commands, biased in turns toward filling and draining the stack
	task automatic run_random(input int count, input int hold_at, input int pause_at);
		int n;
		int r;
		int sel;
		bit push_heavy;
		logic [CMD_W-1:0] op;
		logic [WORD_W-1:0] value;
		n = 0;
		key_pool[0] = $urandom;
		key_pool[1] = $urandom;
		key_pool[2] = $urandom_range(0, 3);
		key_pool[3] = 32'h80000000;
		while (n < count) begin
			if (n == hold_at) hold_request = 1'b1;
			if (n == pause_at) wait_drained();
			push_heavy = ((n / 20) % 2) == 0;
			r = $urandom_range(0, 99);
			if (r < 5)
				op = CMD_NOP;
			else if (r < 25)
				op = CMD_SEARCH;
			else if (r < (push_heavy ? 85 : 40))
				op = CMD_PUSH;
			else
				op = CMD_POP;
			sel = $urandom_range(0, 9);
			if (sel < 6)
				value = key_pool[$urandom_range(0, 3)];
			else if (sel == 6)
				value = $urandom_range(0, 1) ? 32'h7fffffff : 32'hffffffff;
			else
				value = $urandom;
			drive_cmd(op, value, 1'b0, '0);
			if (op != CMD_NOP) n++;
		end
	endtask

	// result side: random stalls plus the long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// compare every result beat against the oldest pending one
	always @(posedge clk) begin
		stack_beat_t got;
		stack_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status   = m_tuser;
			got.word     = m_tdata[31:0];
			got.position = m_tdata[36:32];
			got.fill     = m_tdata[41:37];
			got.is_last  = m_tlast;
			if (pending_beats.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected beat: status %0d word %h pos %0d fill %0d last %0b",
						got.status, got.word, got.position, got.fill, got.is_last);
			end else begin
				want = pending_beats.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch: expected status %0d word %h pos %0d fill %0d last %0b,",
							" got status %0d word %h pos %0d fill %0d last %0b"},
							want.status, want.word, want.position, want.fill, want.is_last,
							got.status, got.word, got.position, got.fill, got.is_last);
				end
			end
		end
	end

	// watchdog on cycles without a beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		shadow_fill = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			for (int k = 0; k < directed_rows[i].reps; k++)
				drive_cmd(directed_rows[i].op, directed_rows[i].value,
					directed_rows[i].typed, directed_rows[i].typed_beat);
		wait_drained();

		// no idling, with a long hold-off so the input side backs up
		run_random(PHASE_ITEMS, 10, -1);
		wait_drained();

		send_idle_pct = 79;
		run_random(PHASE_ITEMS, -1, 26);
		wait_drained();

		send_idle_pct  = 0;
		recv_stall_pct = 79;
		run_random(PHASE_ITEMS, -1, -1);
		wait_drained();

		send_idle_pct  = 34;
		recv_stall_pct = 34;
		run_random(PHASE_ITEMS, -1, -1);
		wait_drained();

		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatch_count == 0 && pending_beats.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/lss_pkg.sv
hw/rtl/lss_front.sv
hw/rtl/lss_queue.sv
hw/rtl/lss_back.sv
hw/rtl/lifo_stack_with_search_unit.sv
tb/tb_lifo_stack_with_search_unit.sv
